// File: design/dfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DFA acceptor package
// Shared types and fixed codes of the table-driven word acceptor.
// ----------------------------------------------------------------------------
package dfa_pkg;

    localparam int STATE_W = 4;
    localparam int SLOT_W  = 4;
    localparam int CHAR_W  = 8;

    localparam logic [1:0] ACT_SYMBOL = 2'd0;
    localparam logic [1:0] ACT_TRANS  = 2'd1;
    localparam logic [1:0] ACT_FINAL  = 2'd2;
    localparam logic [1:0] ACT_CHAR   = 2'd3;

    localparam logic [1:0] CFG_START_STATE   = 2'd0;
    localparam logic [1:0] CFG_ALPHABET_SIZE = 2'd1;
    localparam logic [1:0] CFG_EMPTY_MARKER  = 2'd2;

    localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
    localparam logic [1:0] VERDICT_UNKNOWN   = 2'd1;
    localparam logic [1:0] VERDICT_MISSING   = 2'd2;
    localparam logic [1:0] VERDICT_NONFINAL  = 2'd3;

    typedef enum logic [1:0] {
        WS_RUN     = 2'd0,
        WS_UNKNOWN = 2'd1,
        WS_MISSING = 2'd2,
        WS_EMPTY   = 2'd3
    } word_status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_STEP = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } match_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] state;
    } trans_entry_t;

endpackage
`default_nettype wire

// File: design/dfa_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DFA acceptor channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface dfa_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [3:0] state_index;
    logic [3:0] symbol_index;
    logic [7:0] char_value;
    logic [3:0] next_state;
    logic       next_valid;
    logic       final_flag;
    logic       last;

    modport source (
        output valid, action, state_index, symbol_index, char_value,
               next_state, next_valid, final_flag, last,
        input  ready
    );
    modport sink (
        input  valid, action, state_index, symbol_index, char_value,
               next_state, next_valid, final_flag, last,
        output ready
    );
endinterface

interface dfa_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [1:0] verdict;
    logic [3:0] end_state;

    modport source (
        output valid, accepted, verdict, end_state,
        input  ready
    );
    modport sink (
        input  valid, accepted, verdict, end_state,
        output ready
    );
endinterface

interface dfa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

// File: design/dfa_alpha_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DFA alphabet matcher
// Holds the alphabet symbols and finds the highest slot in use that
// matches a word character.
// ----------------------------------------------------------------------------
module dfa_alpha_match #(
    parameter int NUM_SLOTS = 16,
    parameter int IDX_W     = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [IDX_W-1:0]         wr_slot,
    input  wire logic [dfa_pkg::CHAR_W-1:0] wr_char,
    input  wire logic [dfa_pkg::CHAR_W-1:0] ch,
    input  wire logic [4:0]               alphabet_size,
    output dfa_pkg::match_t               match
);

    localparam int DEPTH = 1 << IDX_W;

    logic [dfa_pkg::CHAR_W-1:0] symbol_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            symbol_reg[wr_slot] <= wr_char;
        end
    end

    always_comb
    begin
        match = '0;
        for (int a = 0; a < NUM_SLOTS; a++)
        begin
            if ((5'(a) < alphabet_size) && (symbol_reg[a] == ch))
            begin
                match.hit  = 1'b1;
                match.slot = dfa_pkg::SLOT_W'(a);
            end
        end
    end

endmodule
`default_nettype wire

// File: design/dfa_trans_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DFA transition memory
// Synchronous transition table with a registered read and a
// reset-cleared valid bit per entry.
// ----------------------------------------------------------------------------
module dfa_trans_mem #(
    parameter int ADDR_W = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [ADDR_W-1:0]     wr_addr,
    input  wire dfa_pkg::trans_entry_t wr_entry,
    input  wire logic                  rd_en,
    input  wire logic [ADDR_W-1:0]     rd_addr,
    output dfa_pkg::trans_entry_t      rd_entry
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [dfa_pkg::STATE_W-1:0] state_mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [dfa_pkg::STATE_W-1:0] rd_state_reg;
    logic                        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_entry.state;
        end
        if (rd_en)
        begin
            rd_state_reg <= state_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= wr_entry.valid;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry.valid = rd_valid_reg;
    assign rd_entry.state = rd_state_reg;

endmodule
`default_nettype wire

// File: design/dfa_word_acceptor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DFA word acceptor
// Table-driven deterministic automaton that checks words character by
// character and reports one verdict per word.
//
// Usage: the item channel carries load beats (alphabet symbol, transition,
// final mark) and word character beats. A load takes effect in the cycle it
// is accepted and the channel stays ready. A character beat has two steps:
// the alphabet compare and the transition memory read as it is accepted,
// then the state update in ST_STEP from the registered read. The item
// channel is not ready in ST_STEP, so a new beat waits for the step to end.
// A character beat with last set produces one result beat, loaded into the
// output register as its step ends. The output register frees the block to
// take further beats while a result waits; only a second result meeting a
// full, stalled output register holds the block. The cfg channel is always
// ready. Reset clears all transitions and final marks, restores the register
// defaults and starts a fresh word; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dfa_word_acceptor #(
    parameter int MAX_STATES  = 16,
    parameter int MAX_SYMBOLS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dfa_in_if.sink    item,
    dfa_out_if.source result,
    dfa_cfg_if.sink   cfg
);

    localparam int NS     = (MAX_STATES > 16) ? 16 : MAX_STATES;
    localparam int NY     = (MAX_SYMBOLS > 16) ? 16 : MAX_SYMBOLS;
    localparam int SW     = $clog2(NS);
    localparam int YW     = (NY > 1) ? $clog2(NY) : 1;
    localparam int AW     = SW + YW;
    localparam int FDEPTH = 1 << SW;

    dfa_pkg::ctrl_state_t  state_reg, state_next;
    dfa_pkg::word_status_t status_reg, status_eff, status_issue, status_fin;

    logic [3:0]     start_state_reg;
    logic [4:0]     alphabet_size_reg;
    logic [7:0]     empty_marker_reg;
    logic [3:0]     cur_reg;
    logic           at_word_start_reg;
    logic           last_reg;
    logic [FDEPTH-1:0] final_reg;
    logic           out_valid_reg;
    logic           out_accepted_reg;
    logic [1:0]     out_verdict_reg;
    logic [3:0]     out_end_state_reg;

    logic           item_fire;
    logic           char_fire;
    logic           state_ok;
    logic           slot_ok;
    logic           alpha_wr;
    logic           trans_wr;
    logic           final_wr;
    logic           item_ready;
    logic           step_done;
    logic           out_load;
    logic [3:0]     cur_eff;
    logic [3:0]     cur_fin;
    logic           fin;
    logic           res_accepted;
    logic [1:0]     res_verdict;

    dfa_pkg::match_t       match;
    dfa_pkg::trans_entry_t wr_entry;
    dfa_pkg::trans_entry_t rd_entry;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg   <= 4'd1;
            alphabet_size_reg <= 5'd0;
            empty_marker_reg  <= 8'd114;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                dfa_pkg::CFG_START_STATE:   start_state_reg   <= cfg.data[3:0];
                dfa_pkg::CFG_ALPHABET_SIZE: alphabet_size_reg <= cfg.data[4:0];
                dfa_pkg::CFG_EMPTY_MARKER:  empty_marker_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    assign item.ready = item_ready;
    assign item_fire  = item.valid && item_ready;
    assign char_fire  = item_fire && (item.action == dfa_pkg::ACT_CHAR);
    assign state_ok   = 32'(item.state_index) < MAX_STATES;
    assign slot_ok    = 32'(item.symbol_index) < MAX_SYMBOLS;
    assign alpha_wr   = item_fire && (item.action == dfa_pkg::ACT_SYMBOL) && slot_ok;
    assign trans_wr   = item_fire && (item.action == dfa_pkg::ACT_TRANS) && slot_ok
                        && state_ok;
    assign final_wr   = item_fire && (item.action == dfa_pkg::ACT_FINAL) && state_ok;

    dfa_alpha_match #(
        .NUM_SLOTS (NY),
        .IDX_W     (YW)
    ) u_match (
        .clk           (clk),
        .wr_en         (alpha_wr),
        .wr_slot       (item.symbol_index[YW-1:0]),
        .wr_char       (item.char_value),
        .ch            (item.char_value),
        .alphabet_size (alphabet_size_reg),
        .match         (match)
    );

    assign wr_entry.valid = item.next_valid;
    assign wr_entry.state = item.next_state;

    dfa_trans_mem #(
        .ADDR_W (AW)
    ) u_trans (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (trans_wr),
        .wr_addr  ({item.state_index[SW-1:0], item.symbol_index[YW-1:0]}),
        .wr_entry (wr_entry),
        .rd_en    (char_fire),
        .rd_addr  ({cur_eff[SW-1:0], match.slot[YW-1:0]}),
        .rd_entry (rd_entry)
    );

    always_comb
    begin
        if (at_word_start_reg)
        begin
            cur_eff    = start_state_reg;
            status_eff = (item.char_value == empty_marker_reg) ? dfa_pkg::WS_EMPTY
                                                               : dfa_pkg::WS_RUN;
        end
        else
        begin
            cur_eff    = cur_reg;
            status_eff = status_reg;
        end

        if (status_eff != dfa_pkg::WS_RUN)
        begin
            status_issue = status_eff;
        end
        else if (!match.hit)
        begin
            status_issue = dfa_pkg::WS_UNKNOWN;
        end
        else if (32'(cur_eff) >= MAX_STATES)
        begin
            status_issue = dfa_pkg::WS_MISSING;
        end
        else
        begin
            status_issue = dfa_pkg::WS_RUN;
        end
    end

    always_comb
    begin
        status_fin = status_reg;
        cur_fin    = cur_reg;
        if (status_reg == dfa_pkg::WS_RUN)
        begin
            if (rd_entry.valid)
            begin
                cur_fin = rd_entry.state;
            end
            else
            begin
                status_fin = dfa_pkg::WS_MISSING;
            end
        end
        fin = (32'(cur_fin) < MAX_STATES) && final_reg[cur_fin[SW-1:0]];

        case (status_fin)
            dfa_pkg::WS_EMPTY:
            begin
                res_accepted = 1'b1;
                res_verdict  = dfa_pkg::VERDICT_ACCEPT;
            end
            dfa_pkg::WS_UNKNOWN:
            begin
                res_accepted = 1'b0;
                res_verdict  = dfa_pkg::VERDICT_UNKNOWN;
            end
            dfa_pkg::WS_MISSING:
            begin
                res_accepted = 1'b0;
                res_verdict  = dfa_pkg::VERDICT_MISSING;
            end
            default:
            begin
                res_accepted = fin;
                res_verdict  = fin ? dfa_pkg::VERDICT_ACCEPT : dfa_pkg::VERDICT_NONFINAL;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dfa_pkg::ST_IDLE:
            begin
                if (char_fire)
                begin
                    state_next = dfa_pkg::ST_STEP;
                end
            end
            dfa_pkg::ST_STEP:
            begin
                if (step_done)
                begin
                    state_next = dfa_pkg::ST_IDLE;
                end
            end
            default: state_next = dfa_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_ready = 1'b0;
        step_done  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            dfa_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            dfa_pkg::ST_STEP:
            begin
                step_done = !(last_reg && out_valid_reg && !result.ready);
                out_load  = step_done && last_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= dfa_pkg::ST_IDLE;
            cur_reg           <= 4'd1;
            status_reg        <= dfa_pkg::WS_RUN;
            at_word_start_reg <= 1'b1;
            last_reg          <= 1'b0;
            final_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (final_wr)
            begin
                final_reg[item.state_index[SW-1:0]] <= item.final_flag;
            end
            if (char_fire)
            begin
                cur_reg           <= cur_eff;
                status_reg        <= status_issue;
                last_reg          <= item.last;
                at_word_start_reg <= 1'b0;
            end
            else if (step_done)
            begin
                cur_reg    <= cur_fin;
                status_reg <= status_fin;
                if (last_reg)
                begin
                    at_word_start_reg <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_accepted_reg  <= res_accepted;
            out_verdict_reg   <= res_verdict;
            out_end_state_reg <= cur_fin;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.accepted  = out_accepted_reg;
    assign result.verdict   = out_verdict_reg;
    assign result.end_state = out_end_state_reg;

endmodule
`default_nettype wire

// File: sim/dfa_acceptor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA word acceptor checker
// Watches the item, register and result channels. It keeps its own copy of
// the alphabet, transition table, final marks and word progress, updates it
// on every accepted beat, and compares each result beat with the oldest
// predicted word verdict. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------
module dfa_acceptor_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    dfa_in_if         item,
    dfa_out_if        result,
    dfa_cfg_if        cfg,
    output int        fail_count,
    output int        pending
);
    import dfa_pkg::*;

    localparam int STATE_COUNT = 1 << STATE_W;
    localparam int SLOT_COUNT  = 1 << SLOT_W;

    typedef struct packed {
        logic               accepted;
        logic [1:0]         verdict;
        logic [STATE_W-1:0] end_state;
    } word_verdict_t;

    logic [CHAR_W-1:0]  sym_tab [SLOT_COUNT];
    trans_entry_t       trans_tab [STATE_COUNT][SLOT_COUNT];
    logic               final_tab [STATE_COUNT];
    logic [STATE_W-1:0] cur_state;
    word_status_t       status;
    logic               at_start;

    logic [STATE_W-1:0] start_reg;
    logic [4:0]         size_reg;
    logic [CHAR_W-1:0]  marker_reg;

    word_verdict_t      word_verdicts_due [$];

    function automatic void clear_automaton();
        for (int s = 0; s < STATE_COUNT; s++)
        begin
            final_tab[s] = 1'b0;
            for (int y = 0; y < SLOT_COUNT; y++)
            begin
                trans_tab[s][y] = '0;
            end
        end
        for (int y = 0; y < SLOT_COUNT; y++)
        begin
            sym_tab[y] = '0;
        end
        start_reg  = 4'd1;
        size_reg   = 5'd0;
        marker_reg = 8'd114;
        cur_state  = 4'd1;
        status     = WS_RUN;
        at_start   = 1'b1;
    endfunction

    // Applies the beat on the item channel and returns 1 when it ends a word.
    function automatic bit advance_automaton(output word_verdict_t verdict_out);
        int         span;
        bit         hit;
        logic [3:0] slot;
        verdict_out = '0;
        case (item.action)
            ACT_SYMBOL:
            begin
                sym_tab[item.symbol_index] = item.char_value;
                return 1'b0;
            end
            ACT_TRANS:
            begin
                trans_tab[item.state_index][item.symbol_index] =
                    {item.next_valid, item.next_state};
                return 1'b0;
            end
            ACT_FINAL:
            begin
                final_tab[item.state_index] = item.final_flag;
                return 1'b0;
            end
            default:
            begin
                if (at_start)
                begin
                    at_start  = 1'b0;
                    cur_state = start_reg;
                    status    = (item.char_value == marker_reg) ? WS_EMPTY : WS_RUN;
                end
                if (status == WS_RUN)
                begin
                    span = (size_reg > SLOT_COUNT) ? SLOT_COUNT : size_reg;
                    hit  = 1'b0;
                    slot = '0;
                    for (int a = 0; a < span; a++)
                    begin
                        if (sym_tab[a] == item.char_value)
                        begin
                            hit  = 1'b1;
                            slot = SLOT_W'(a);
                        end
                    end
                    if (!hit)
                        status = WS_UNKNOWN;
                    else if (!trans_tab[cur_state][slot].valid)
                        status = WS_MISSING;
                    else
                        cur_state = trans_tab[cur_state][slot].state;
                end
                if (!item.last)
                    return 1'b0;
                at_start = 1'b1;
                case (status)
                    WS_EMPTY:   verdict_out = {1'b1, VERDICT_ACCEPT, cur_state};
                    WS_UNKNOWN: verdict_out = {1'b0, VERDICT_UNKNOWN, cur_state};
                    WS_MISSING: verdict_out = {1'b0, VERDICT_MISSING, cur_state};
                    default:
                    begin
                        if (final_tab[cur_state])
                            verdict_out = {1'b1, VERDICT_ACCEPT, cur_state};
                        else
                            verdict_out = {1'b0, VERDICT_NONFINAL, cur_state};
                    end
                endcase
                return 1'b1;
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [3:0] want,
                                 input logic [3:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        clear_automaton();
    end

    always @(posedge clk or negedge rst_n)
    begin
        word_verdict_t seen;
        word_verdict_t due;
        word_verdict_t predicted;
        if (!rst_n)
        begin
            clear_automaton();
            word_verdicts_due.delete();
            pending = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen = {result.accepted, result.verdict, result.end_state};
                if (word_verdicts_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat with no word pending, expected none, actual %0b/%0d/%0d",
                             $time, seen.accepted, seen.verdict, seen.end_state);
                end
                else
                begin
                    due = word_verdicts_due.pop_front();
                    compare_field("accepted", 4'(due.accepted), 4'(seen.accepted));
                    compare_field("verdict", 4'(due.verdict), 4'(seen.verdict));
                    compare_field("end_state", due.end_state, seen.end_state);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_START_STATE:   start_reg  = cfg.data[STATE_W-1:0];
                    CFG_ALPHABET_SIZE: size_reg   = cfg.data[4:0];
                    CFG_EMPTY_MARKER:  marker_reg = cfg.data;
                    default:           ;
                endcase
            end
            if (item.valid && item.ready)
            begin
                if (advance_automaton(predicted))
                    word_verdicts_due.push_back(predicted);
            end
            pending = word_verdicts_due.size();
        end
    end

endmodule

// File: sim/tb_dfa_word_acceptor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DFA word acceptor testbench
// Drives load and word character beats into the acceptor and takes its
// results with random stalls. A directed opening covers the empty word,
// unknown symbols, missing transitions, non-final endings, duplicate
// alphabet entries and loads inside a word. Random phases under several
// register settings then stream mostly well-formed words over a randomly
// filled transition table. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_dfa_word_acceptor;
    import dfa_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]         action;
        logic [STATE_W-1:0] state_index;
        logic [SLOT_W-1:0]  symbol_index;
        logic [CHAR_W-1:0]  char_value;
        logic [STATE_W-1:0] next_state;
        logic               next_valid;
        logic               final_flag;
        logic               last;
    } item_beat_t;

    logic clk;
    logic rst_n;

    dfa_in_if  item_ch ();
    dfa_out_if result_ch ();
    dfa_cfg_if cfg_ch ();

    int                check_failures;
    int                verdicts_pending;
    int                cycle_count = 0;
    int                beats_sent = 0;
    int                hold_req = 0;
    bit                src_idle_en = 1'b1;
    bit                sink_idle_en = 1'b1;
    int                alpha_in_use = 0;
    logic [CHAR_W-1:0] marker_now = 8'd114;
    logic [CHAR_W-1:0] sym_shadow [16];

    dfa_word_acceptor u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    dfa_acceptor_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg        (cfg_ch),
        .fail_count (check_failures),
        .pending    (verdicts_pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The result side: random stall bursts, plus one long hold when asked.
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold_req) @(negedge clk);
                hold_req = 0;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    function automatic item_beat_t random_beat();
        logic [31:0] r;
        r = $urandom;
        return r[24:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic offer_beat(input item_beat_t b);
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= b.action;
        item_ch.state_index  <= b.state_index;
        item_ch.symbol_index <= b.symbol_index;
        item_ch.char_value   <= b.char_value;
        item_ch.next_state   <= b.next_state;
        item_ch.next_valid   <= b.next_valid;
        item_ch.final_flag   <= b.final_flag;
        item_ch.last         <= b.last;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch, input logic is_last);
        item_beat_t b;
        b = random_beat();
        b.action     = ACT_CHAR;
        b.char_value = ch;
        b.last       = is_last;
        offer_beat(b);
    endtask

    task automatic load_symbol(input logic [3:0] slot, input logic [7:0] ch);
        item_beat_t b;
        b = random_beat();
        b.action       = ACT_SYMBOL;
        b.symbol_index = slot;
        b.char_value   = ch;
        sym_shadow[slot] = ch;
        offer_beat(b);
    endtask

    task automatic load_trans(input logic [3:0] src, input logic [3:0] slot,
                              input logic [3:0] dst, input logic ok);
        item_beat_t b;
        b = random_beat();
        b.action       = ACT_TRANS;
        b.state_index  = src;
        b.symbol_index = slot;
        b.next_state   = dst;
        b.next_valid   = ok;
        offer_beat(b);
    endtask

    task automatic load_final(input logic [3:0] st, input logic flag);
        item_beat_t b;
        b = random_beat();
        b.action      = ACT_FINAL;
        b.state_index = st;
        b.final_flag  = flag;
        offer_beat(b);
    endtask

    task automatic send_random_load();
        item_beat_t b;
        b = random_beat();
        case ($urandom_range(0, 2))
            0:       b.action = ACT_SYMBOL;
            1:       b.action = ACT_TRANS;
            default: b.action = ACT_FINAL;
        endcase
        if (b.action == ACT_TRANS)
            b.next_valid = ($urandom_range(0, 9) != 0);
        if (b.action == ACT_SYMBOL)
            sym_shadow[b.symbol_index] = b.char_value;
        offer_beat(b);
    endtask

    task automatic send_word(input int len);
        item_beat_t b;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_random_load();
            b = random_beat();
            b.action = ACT_CHAR;
            b.last   = (i == len - 1);
            if (i == 0 && $urandom_range(0, 14) == 0)
                b.char_value = marker_now;
            else if (alpha_in_use > 0 && $urandom_range(0, 19) != 0)
                b.char_value = sym_shadow[$urandom_range(0, alpha_in_use - 1)];
            offer_beat(b);
        end
    endtask

    task automatic settle();
        item_ch.valid <= 1'b0;
        while (verdicts_pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_config(input logic [3:0] start, input logic [4:0] size,
                                input logic [7:0] marker);
        logic [7:0] vals [3];
        logic [1:0] idxs [3];
        vals = '{{4'd0, start}, {3'd0, size}, marker};
        idxs = '{CFG_START_STATE, CFG_ALPHABET_SIZE, CFG_EMPTY_MARKER};
        for (int k = 0; k < 3; k++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idxs[k];
            cfg_ch.data  <= vals[k];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
        alpha_in_use = (size > 16) ? 16 : size;
        marker_now   = marker;
    endtask

    task automatic fill_tables();
        for (int s = 0; s < 16; s++)
        begin
            for (int y = 0; y < 16; y++)
            begin
                load_trans(4'(s), 4'(y), 4'($urandom), $urandom_range(0, 9) != 0);
            end
        end
        for (int s = 0; s < 16; s++)
        begin
            load_final(4'(s), 1'($urandom));
        end
    endtask

    task automatic run_phase(input logic [3:0] start, input logic [4:0] size,
                             input logic [7:0] marker, input int beats, input int hold);
        int goal;
        settle();
        write_config(start, size, marker);
        hold_req = hold;
        goal = beats_sent + beats;
        while (beats_sent < goal)
        begin
            if ($urandom_range(0, 99) < 85)
                send_word(($urandom_range(0, 9) == 0) ? $urandom_range(6, 12)
                                                       : $urandom_range(1, 5));
            else
                send_random_load();
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.action       = ACT_SYMBOL;
        item_ch.state_index  = '0;
        item_ch.symbol_index = '0;
        item_ch.char_value   = '0;
        item_ch.next_state   = '0;
        item_ch.next_valid   = 1'b0;
        item_ch.final_flag   = 1'b0;
        item_ch.last         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_START_STATE;
        cfg_ch.data          = '0;
        for (int y = 0; y < 16; y++)
        begin
            sym_shadow[y] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Register defaults: empty alphabet, so only the empty word is accepted.
        send_char(8'd114, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        for (int y = 0; y < 16; y++)
        begin
            load_symbol(4'(y), 8'(y * 17));
        end
        // Slots 3 and 9 share a symbol, so slot 9 must win the match.
        load_symbol(4'd9, 8'h33);
        load_trans(4'd1, 4'd9, 4'd15, 1'b1);
        load_trans(4'd1, 4'd3, 4'd2, 1'b1);
        load_trans(4'd15, 4'd15, 4'd0, 1'b1);
        load_final(4'd0, 1'b1);

        settle();
        write_config(4'd1, 5'd16, 8'd114);
        send_char(8'h33, 1'b0);
        send_char(8'hFF, 1'b1);
        send_char(8'h33, 1'b1);
        send_char(8'h00, 1'b1);
        send_char(8'h42, 1'b0);
        send_char(8'h33, 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'h33, 1'b1);
        send_char(8'd114, 1'b0);
        send_char(8'h00, 1'b1);
        send_char(8'h33, 1'b0);
        load_trans(4'd15, 4'd0, 4'd7, 1'b1);
        send_char(8'h00, 1'b1);
        load_final(4'd0, 1'b0);
        send_char(8'h33, 1'b0);
        send_char(8'hFF, 1'b1);
        load_trans(4'd1, 4'd9, 4'd4, 1'b0);
        send_char(8'h33, 1'b1);

        fill_tables();
        run_phase(4'd0, 5'd16, 8'h00, 360, 0);
        run_phase(4'd15, 5'd31, 8'hFF, 360, 150);
        run_phase(4'd7, 5'd5, 8'($urandom), 360, 0);
        run_phase(4'd3, 5'd0, 8'd114, 100, 0);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        run_phase(4'($urandom), 5'd16, 8'($urandom), 360, 0);

        settle();
        repeat (8) @(negedge clk);
        if (check_failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
